[hw/rtl/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared widths, operation and status codes for the bounded byte deque.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // default ring capacity
  localparam int CAPACITY = 16;

  // fixed payload widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // request held while the memory read completes
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [STATUS_W-1:0] status;
  } pend_t;

endpackage

[hw/rtl/bbd_if.sv]
// ----------------------------------------------------------------------------
// bbd_if
// Request and response channels of the bounded byte deque.
// ----------------------------------------------------------------------------
interface bbd_req_if;
  logic                          valid;
  logic                          ready;
  logic [bbd_pkg::OP_W-1:0]      op;
  logic [bbd_pkg::DATA_W-1:0]    data_in;
  logic [bbd_pkg::POS_W-1:0]     position;

  modport source (output valid, op, data_in, position, input ready);
  modport sink   (input valid, op, data_in, position, output ready);
endinterface

interface bbd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbd_pkg::STATUS_W-1:0]  status;
  logic [bbd_pkg::DATA_W-1:0]    data_out;
  logic [bbd_pkg::COUNT_W-1:0]   count;
  logic [bbd_pkg::DATA_W-1:0]    last_value;
  logic                          last_valid;

  modport source (output valid, status, data_out, count, last_value, last_valid,
                  input ready);
  modport sink   (input valid, status, data_out, count, last_value, last_valid,
                  output ready);
endinterface

[hw/rtl/bbd_ram.sv]
// ----------------------------------------------------------------------------
// bbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bounded_byte_deque.sv]
// ----------------------------------------------------------------------------
// bounded_byte_deque
// Fixed-capacity byte deque kept in a ring buffer with a head index and count.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         transfer
//  req      in   op, data_in, position                           valid & ready
//  rsp      out  status, data_out, count, last_value, last_valid valid & ready
//
//  A request is accepted in S_IDLE, where the ring read is issued; in S_RESP
//  the registered read data of the element memory goes into the response
//  register once rsp is free.
//  Reset (rst, synchronous) empties the deque; memory contents are not cleared.
//  A new request is taken while a response still waits on rsp; a stalled
//  response holds the block in its response state until rsp frees up.
module bounded_byte_deque #(
  parameter int CAPACITY = bbd_pkg::CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  bbd_req_if.sink        req,
  bbd_rsp_if.source      rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > bbd_pkg::POS_W) ? CW : bbd_pkg::POS_W;
  localparam int SW = IW + 1;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  // ring index add with one wrap
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[IW-1:0];
  endfunction

  logic                         state;
  logic [IW-1:0]                head;
  logic [CW-1:0]                count;
  logic [bbd_pkg::DATA_W-1:0]   tail;
  bbd_pkg::pend_t               pend;

  logic [IW-1:0]                head_next;
  logic [CW-1:0]                count_next;
  logic [bbd_pkg::DATA_W-1:0]   tail_next;
  logic [bbd_pkg::STATUS_W-1:0] status_c;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic [IW-1:0]                addr_a;
  logic [IW-1:0]                addr_b;
  logic [bbd_pkg::DATA_W-1:0]   rd_a;
  logic [bbd_pkg::DATA_W-1:0]   rd_b;
  logic                         accept;
  logic                         load;
  logic                         full;
  logic                         empty;
  logic [bbd_pkg::POS_W-1:0]    off;
  logic [MW-1:0]                cnt_ext;
  logic [CW-1:0]                cnt_m1;
  logic [CW-1:0]                cnt_m2;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_RESP) && (!rsp.valid || rsp.ready);
  assign full      = (count >= CAP_C);
  assign empty     = (count == '0);
  assign off       = (req.position <= bbd_pkg::POS_W'(1)) ? '0
                                                          : req.position - 1'b1;
  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign cnt_ext   = MW'(count);

  // decode request against current ring state
  always_comb begin
    head_next  = head;
    count_next = count;
    tail_next  = tail;
    status_c   = bbd_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = ring_add(head, count[IW-1:0]);
    addr_a     = head;
    addr_b     = ring_add(head, cnt_m2[IW-1:0]);
    unique case (req.op)
      bbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_c = bbd_pkg::ST_FULL;
        end else begin
          head_next  = (head == '0) ? LAST_IDX : head - IW'(1);
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + CW'(1);
          if (empty) begin
            tail_next = req.data_in;
          end
        end
      end
      bbd_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_c = bbd_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          tail_next  = req.data_in;
        end
      end
      bbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_c = bbd_pkg::ST_EMPTY;
        end else begin
          head_next  = ring_add(head, IW'(1));
          count_next = cnt_m1;
        end
      end
      bbd_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_c = bbd_pkg::ST_EMPTY;
        end else begin
          addr_a     = ring_add(head, cnt_m1[IW-1:0]);
          count_next = cnt_m1;
        end
      end
      bbd_pkg::OP_READ: begin
        addr_a = ring_add(head, IW'(off));
        if (empty) begin
          status_c = bbd_pkg::ST_EMPTY;
        end else if (MW'(off) >= cnt_ext) begin
          status_c = bbd_pkg::ST_BEYOND;
        end
      end
      bbd_pkg::OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // element store, mirrored so that popped byte and new tail read together
  bbd_ram #(
    .WIDTH (bbd_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram_a (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata (req.data_in),
    .re    (accept),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  bbd_ram #(
    .WIDTH (bbd_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram_b (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata (req.data_in),
    .re    (accept),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RESP;
            head  <= head_next;
            count <= count_next;
          end
        end
        S_RESP: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // pending request and tail byte
  always_ff @(posedge clk) begin
    if (accept) begin
      pend.op     <= req.op;
      pend.status <= status_c;
      tail        <= tail_next;
    end else if (load && pend.op == bbd_pkg::OP_POP_BACK &&
                 pend.status == bbd_pkg::ST_OK && count != '0) begin
      tail <= rd_b;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status <= pend.status;
      rsp.count  <= cnt_ext[bbd_pkg::COUNT_W-1:0];
      rsp.last_valid <= (count != '0);
      if (pend.status == bbd_pkg::ST_OK &&
          (pend.op == bbd_pkg::OP_POP_FRONT || pend.op == bbd_pkg::OP_POP_BACK ||
           pend.op == bbd_pkg::OP_READ)) begin
        rsp.data_out <= rd_a;
      end else begin
        rsp.data_out <= '0;
      end
      if (count == '0) begin
        rsp.last_value <= '0;
      end else if (pend.op == bbd_pkg::OP_POP_BACK && pend.status == bbd_pkg::ST_OK) begin
        rsp.last_value <= rd_b;
      end else begin
        rsp.last_value <= tail;
      end
    end
  end

  // count stays within capacity
  assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("element count above capacity");

  // head index stays inside the ring
  assert property (@(posedge clk) disable iff (rst) {1'b0, head} < CAP_S)
    else $error("head index outside ring");

  // a refused or failed request never returns data
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != bbd_pkg::ST_OK |-> rsp.data_out == '0)
    else $error("data on non-ok response");

  // an accepted push into a non-full deque grows it by one
  assert property (@(posedge clk) disable iff (rst)
    accept && !full &&
    (req.op == bbd_pkg::OP_PUSH_FRONT || req.op == bbd_pkg::OP_PUSH_BACK)
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow count");

endmodule

[dv/bounded_byte_deque_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_byte_deque_tb
// Self-checking bench for the ring-buffer byte deque. A short directed list
// walks the empty, single-element, beyond-count and clear cases, then random
// bursts of pushes, pops and reads push the deque between empty and full.
// Every accepted request runs through a local deque model, and each response
// is checked field by field against the oldest prediction. Both channels
// stall in random bursts, and the traffic ends with no stalls at all.
// ----------------------------------------------------------------------------
module bounded_byte_deque_tb;

  // opcodes the block treats as no operation
  localparam logic [bbd_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bbd_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_TAIL   = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_TICKS = 20;

  typedef struct {
    logic [bbd_pkg::OP_W-1:0]   op;
    logic [bbd_pkg::DATA_W-1:0] data_in;
    logic [bbd_pkg::POS_W-1:0]  position;
    bit                         drain_first;
  } deque_req_t;

  typedef struct packed {
    logic [bbd_pkg::STATUS_W-1:0] status;
    logic [bbd_pkg::DATA_W-1:0]   data_out;
    logic [bbd_pkg::COUNT_W-1:0]  count;
    logic [bbd_pkg::DATA_W-1:0]   last_value;
    logic                         last_valid;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbd_req_if req_ch ();
  bbd_rsp_if rsp_ch ();

  bounded_byte_deque u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // model of the deque contents
  logic [bbd_pkg::DATA_W-1:0] shadow_ring [bbd_pkg::CAPACITY];
  int unsigned       shadow_head  = 0;
  int unsigned       shadow_count = 0;

  deque_req_t request_backlog [$];
  deque_rsp_t awaited_rsp [$];

  int  plan_count   = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  bit  req_fired    = 1'b0;
  int  mismatches   = 0;
  int  checked      = 0;
  int  accepted_cnt = 0;
  int  status_tally [4] = '{default: 0};
  deque_req_t next_req;
  deque_req_t taken_req;
  deque_rsp_t predicted;
  deque_rsp_t wanted;
  deque_rsp_t observed;

  // apply one request to the model and return the response it produces
  function automatic deque_rsp_t apply_request(deque_req_t r);
    deque_rsp_t  res;
    int unsigned offset;
    res = '0;
    res.status = bbd_pkg::ST_OK;
    case (r.op)
      bbd_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= bbd_pkg::CAPACITY) begin
          res.status = bbd_pkg::ST_FULL;
        end else begin
          shadow_head = (shadow_head + bbd_pkg::CAPACITY - 1) % bbd_pkg::CAPACITY;
          shadow_ring[shadow_head] = r.data_in;
          shadow_count++;
        end
      end
      bbd_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= bbd_pkg::CAPACITY) begin
          res.status = bbd_pkg::ST_FULL;
        end else begin
          shadow_ring[(shadow_head + shadow_count) % bbd_pkg::CAPACITY] = r.data_in;
          shadow_count++;
        end
      end
      bbd_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = bbd_pkg::ST_EMPTY;
        end else begin
          res.data_out = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % bbd_pkg::CAPACITY;
          shadow_count--;
        end
      end
      bbd_pkg::OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = bbd_pkg::ST_EMPTY;
        end else begin
          res.data_out =
            shadow_ring[(shadow_head + shadow_count - 1) % bbd_pkg::CAPACITY];
          shadow_count--;
        end
      end
      bbd_pkg::OP_READ: begin
        if (shadow_count == 0) begin
          res.status = bbd_pkg::ST_EMPTY;
        end else begin
          offset = (r.position <= 1) ? 0 : r.position - 1;
          if (offset >= shadow_count) begin
            res.status = bbd_pkg::ST_BEYOND;
          end else begin
            res.data_out = shadow_ring[(shadow_head + offset) % bbd_pkg::CAPACITY];
          end
        end
      end
      bbd_pkg::OP_CLEAR: begin
        shadow_count = 0;
        shadow_head  = 0;
      end
      default: begin
      end
    endcase
    res.count = bbd_pkg::COUNT_W'(shadow_count);
    if (shadow_count != 0) begin
      res.last_value =
        shadow_ring[(shadow_head + shadow_count - 1) % bbd_pkg::CAPACITY];
      res.last_valid = 1'b1;
    end
    return res;
  endfunction

  // append one request, tracking roughly how full the deque will be
  task automatic queue_req(input logic [bbd_pkg::OP_W-1:0] op,
                           input logic [bbd_pkg::DATA_W-1:0] data,
                           input logic [bbd_pkg::POS_W-1:0] pos, input bit drain);
    deque_req_t item;
    item.op          = op;
    item.data_in     = data;
    item.position    = pos;
    item.drain_first = drain;
    request_backlog.push_back(item);
    if ((op == bbd_pkg::OP_PUSH_FRONT || op == bbd_pkg::OP_PUSH_BACK) &&
        plan_count < bbd_pkg::CAPACITY) begin
      plan_count++;
    end else if ((op == bbd_pkg::OP_POP_FRONT || op == bbd_pkg::OP_POP_BACK) &&
                 plan_count > 0) begin
      plan_count--;
    end else if (op == bbd_pkg::OP_CLEAR) begin
      plan_count = 0;
    end
  endtask

  // request driver: a new request goes out once the previous one transferred
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (request_backlog.size() > 0 &&
                   !(request_backlog[0].drain_first && awaited_rsp.size() > 0)) begin
        next_req = request_backlog.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.op       <= next_req.op;
        req_ch.data_in  <= next_req.data_in;
        req_ch.position <= next_req.position;
        if (request_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 15);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response sink: ready drops in random bursts until the quiet tail
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (request_backlog.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
    end
  end

  // request monitor: predict the response of each request transfer
  always @(posedge clk) begin
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        taken_req.op          = req_ch.op;
        taken_req.data_in     = req_ch.data_in;
        taken_req.position    = req_ch.position;
        taken_req.drain_first = 1'b0;
        predicted = apply_request(taken_req);
        awaited_rsp.push_back(predicted);
        status_tally[predicted.status]++;
        accepted_cnt++;
      end
    end
  end

  // response monitor: check each response transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      observed.status     = rsp_ch.status;
      observed.data_out   = rsp_ch.data_out;
      observed.count      = rsp_ch.count;
      observed.last_value = rsp_ch.last_value;
      observed.last_valid = rsp_ch.last_valid;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected response: status %0d data %02h count %0d last %02h/%0b",
                   observed.status, observed.data_out, observed.count,
                   observed.last_value, observed.last_valid);
        end
      end else begin
        wanted = awaited_rsp.pop_front();
        checked++;
        if (observed.status !== wanted.status || observed.data_out !== wanted.data_out ||
            observed.count !== wanted.count || observed.last_value !== wanted.last_value ||
            observed.last_valid !== wanted.last_valid) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("response %0d: expected status %0d data %02h count %0d last %02h/%0b",
                     checked, wanted.status, wanted.data_out, wanted.count,
                     wanted.last_value, wanted.last_valid);
            $display("response %0d: got      status %0d data %02h count %0d last %02h/%0b",
                     checked, observed.status, observed.data_out, observed.count,
                     observed.last_value, observed.last_valid);
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int                        planned;
    int                        pick;
    int                        burst;
    int                        roll;
    bit                        drain;
    logic [bbd_pkg::OP_W-1:0]  op_sel;
    logic [bbd_pkg::POS_W-1:0] pos_sel;

    req_ch.valid    = 1'b0;
    req_ch.op       = bbd_pkg::OP_PUSH_FRONT;
    req_ch.data_in  = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;

    // directed: empty cases, spare opcodes, reads around the count, clear
    queue_req(bbd_pkg::OP_POP_FRONT, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_POP_BACK, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd0, 1'b0);
    queue_req(OP_SPARE_6, 8'h00, 5'd0, 1'b0);
    queue_req(OP_SPARE_7, 8'hFF, 5'd31, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_BACK, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_FRONT, 8'hFF, 5'd31, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_BACK, 8'hA5, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd1, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd3, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd4, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd16, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd31, 1'b0);
    queue_req(bbd_pkg::OP_POP_BACK, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_POP_FRONT, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_POP_BACK, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd2, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_FRONT, 8'h5A, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_BACK, 8'hC3, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_CLEAR, 8'h00, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_READ, 8'h00, 5'd1, 1'b0);
    queue_req(bbd_pkg::OP_PUSH_BACK, 8'h81, 5'd0, 1'b0);
    queue_req(bbd_pkg::OP_POP_FRONT, 8'h00, 5'd0, 1'b0);

    // random bursts: fill, drain, read scans and mixed traffic
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      pick  = (planned == 0) ? 0 : $urandom_range(0, 9);
      burst = (planned == 0) ? 20 : $urandom_range(4, 20);
      drain = (planned == 0) || ($urandom_range(0, 14) == 0);
      for (int k = 0; k < burst; k++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
          pos_sel = bbd_pkg::POS_W'($urandom_range(0, 31));
        end else begin
          pos_sel = bbd_pkg::POS_W'($urandom_range(0, plan_count + 1));
        end
        if (pick <= 1) begin
          op_sel = $urandom_range(0, 1) ? bbd_pkg::OP_PUSH_BACK : bbd_pkg::OP_PUSH_FRONT;
        end else if (pick <= 3) begin
          op_sel = $urandom_range(0, 1) ? bbd_pkg::OP_POP_BACK : bbd_pkg::OP_POP_FRONT;
        end else if (pick <= 5) begin
          op_sel = (roll < 80) ? bbd_pkg::OP_READ : bbd_pkg::OP_PUSH_BACK;
        end else if (roll < 32) begin
          op_sel = $urandom_range(0, 1) ? bbd_pkg::OP_PUSH_BACK : bbd_pkg::OP_PUSH_FRONT;
        end else if (roll < 56) begin
          op_sel = $urandom_range(0, 1) ? bbd_pkg::OP_POP_BACK : bbd_pkg::OP_POP_FRONT;
        end else if (roll < 92) begin
          op_sel = bbd_pkg::OP_READ;
        end else if (roll < 96) begin
          op_sel = bbd_pkg::OP_CLEAR;
        end else begin
          op_sel = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
        end
        queue_req(op_sel, bbd_pkg::DATA_W'($urandom), pos_sel, drain && (k == 0));
        planned++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (request_backlog.size() > 0 || req_ch.valid || awaited_rsp.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d empty, %0d beyond count, %0d full",
             accepted_cnt, status_tally[bbd_pkg::ST_OK], status_tally[bbd_pkg::ST_EMPTY],
             status_tally[bbd_pkg::ST_BEYOND], status_tally[bbd_pkg::ST_FULL]);
    $display("%0d responses checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("run timed out with %0d responses outstanding", awaited_rsp.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
